FILE: hdl/opl_pkg.sv
// ----------------------------------------------------------------------------
// opl_pkg
// Shared types and codes for the recency-ordered page list.
// ----------------------------------------------------------------------------
`default_nettype none

package opl_pkg;

  localparam int PAGE_W = 16;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_POP_BACK   = 2'd1,
    FN_REMOVE     = 2'd2,
    FN_PEEK       = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [PAGE_W-1:0]  page;
  } opl_in_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  removed_page;
    status_t            status;
    logic [PAGE_W-1:0]  front_page;
    logic [PAGE_W-1:0]  back_page;
    logic [CNT_W-1:0]   entry_count;
  } opl_out_t;

endpackage

`default_nettype wire

FILE: hdl/ordered_page_list.sv
// ----------------------------------------------------------------------------
// ordered_page_list
// Recency-ordered page list kept as a circular buffer in one synchronous RAM.
// ----------------------------------------------------------------------------
// Push front, peek and refused/empty ops: result strobe in the cycle after start.
// Pop back: RAM read for the new tail, skipped if it empties the list.
// Remove: search walk; a match at list position m > 0 then shifts the m earlier
// entries; a front match reads the new front unless that empties the list.
// No match ends at the tail. busy stays high until the result issues; no stall.
// Reset (synchronous, rst_n low) empties the list; RAM contents are not cleared.
`default_nettype none

module ordered_page_list
  import opl_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int PAGE_WIDTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire opl_in_t  in_data,
  output logic          out_valid,
  output opl_out_t      out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = (PAGE_WIDTH < PAGE_W) ? PAGE_WIDTH : PAGE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SEARCH,
    S_FRONT_RD,
    S_SHIFT
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [EW-1:0]   front_r, front_nxt;
  logic [EW-1:0]   back_r, back_nxt;
  logic [EW-1:0]   key_r, key_nxt;
  logic [EW-1:0]   removed_r, removed_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            out_valid_r, out_valid_nxt;
  opl_out_t        out_r, out_nxt;

  logic [EW-1:0]   mem [DEPTH];
  logic [EW-1:0]   rd_data_r;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [EW-1:0]   pg;
  logic [AW-1:0]   head_inc, head_dec;
  logic [CW-1:0]   count_dec;
  logic [EW-1:0]   back_upd;

  // list position to RAM address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(hd) + SW'(pos);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  function automatic opl_out_t pack_res(input logic [EW-1:0] rm, input status_t st,
                                        input logic [EW-1:0] fr, input logic [EW-1:0] bk,
                                        input logic [CW-1:0] cnt);
    opl_out_t r;
    r.removed_page = PAGE_W'(rm);
    r.status       = st;
    r.front_page   = (cnt == '0) ? '0 : PAGE_W'(fr);
    r.back_page    = (cnt == '0) ? '0 : PAGE_W'(bk);
    r.entry_count  = CNT_W'(cnt);
    return r;
  endfunction

  assign pg        = in_data.page[EW-1:0];
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign count_dec = count_r - CW'(1);
  // first shift write lands on the old tail slot when the match was the tail
  assign back_upd  = (pos_r + CW'(1) == count_dec) ? rd_data_r : back_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    key_nxt       = key_r;
    removed_nxt   = removed_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = head_dec;
    mem_wdata     = pg;
    mem_raddr     = phys(head_r, pos_r + CW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.func)
            FN_PUSH_FRONT: begin
              out_valid_nxt = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_nxt = pack_res('0, ST_FULL, front_r, back_r, count_r);
              end else begin
                mem_we    = 1'b1;
                head_nxt  = head_dec;
                front_nxt = pg;
                back_nxt  = (count_r == '0) ? pg : back_r;
                count_nxt = count_r + CW'(1);
                out_nxt   = pack_res('0, ST_OK, pg, (count_r == '0) ? pg : back_r,
                                     count_r + CW'(1));
              end
            end
            FN_POP_BACK: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pack_res('0, ST_EMPTY, front_r, back_r, count_r);
              end else if (count_r == CW'(1)) begin
                out_valid_nxt = 1'b1;
                count_nxt     = '0;
                out_nxt       = pack_res(back_r, ST_OK, front_r, back_r, '0);
              end else begin
                count_nxt   = count_dec;
                removed_nxt = back_r;
                mem_raddr   = phys(head_r, count_r - CW'(2));
                state_nxt   = S_POP_RD;
              end
            end
            FN_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pack_res('0, ST_EMPTY, front_r, back_r, count_r);
              end else begin
                key_nxt   = pg;
                pos_nxt   = '0;
                mem_raddr = phys(head_r, '0);
                state_nxt = S_SEARCH;
              end
            end
            FN_PEEK: begin
              out_valid_nxt = 1'b1;
              out_nxt       = pack_res('0, ST_OK, front_r, back_r, count_r);
            end
          endcase
        end
      end

      S_POP_RD: begin
        back_nxt      = rd_data_r;
        out_valid_nxt = 1'b1;
        out_nxt       = pack_res(removed_r, ST_OK, front_r, rd_data_r, count_r);
        state_nxt     = S_IDLE;
      end

      // rd_data_r holds the entry at pos_r; the next position is already in flight
      S_SEARCH: begin
        if (rd_data_r == key_r) begin
          if (pos_r == '0) begin
            head_nxt  = head_inc;
            count_nxt = count_dec;
            if (count_r == CW'(1)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pack_res(key_r, ST_OK, front_r, back_r, '0);
              state_nxt     = S_IDLE;
            end else begin
              mem_raddr = phys(head_r, CW'(1));
              state_nxt = S_FRONT_RD;
            end
          end else begin
            mem_raddr = phys(head_r, pos_r - CW'(1));
            pos_nxt   = pos_r - CW'(1);
            state_nxt = S_SHIFT;
          end
        end else if (pos_r == count_dec) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pack_res('0, ST_NOT_FOUND, front_r, back_r, count_r);
          state_nxt     = S_IDLE;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end

      S_FRONT_RD: begin
        front_nxt     = rd_data_r;
        out_valid_nxt = 1'b1;
        out_nxt       = pack_res(key_r, ST_OK, rd_data_r, back_r, count_r);
        state_nxt     = S_IDLE;
      end

      // move entry pos_r one place back; head advances once the front is moved
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head_r, pos_r + CW'(1));
        mem_wdata = rd_data_r;
        back_nxt  = back_upd;
        if (pos_r == '0) begin
          head_nxt      = head_inc;
          count_nxt     = count_dec;
          out_valid_nxt = 1'b1;
          out_nxt       = pack_res(key_r, ST_OK, front_r, back_upd, count_dec);
          state_nxt     = S_IDLE;
        end else begin
          mem_raddr = phys(head_r, pos_r - CW'(1));
          pos_nxt   = pos_r - CW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      key_r       <= key_nxt;
      removed_r   <= removed_nxt;
      pos_r       <= pos_nxt;
      out_r       <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("list count above depth");

  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.func == FN_PUSH_FRONT || in_data.func == FN_PEEK)
    |=> out_valid)
    else $error("push or peek gave no result on the next cycle");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> count_r == CW'(DEPTH))
    else $error("full status with spare room");

  a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> count_r != '0 && pos_r < count_r)
    else $error("search walked past the tail");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_ordered_page_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_page_list
// Self-checking bench for the recency-ordered page list. A scoreboard keeps
// its own copy of the list, predicts one result per accepted command and
// compares every strobed result against the oldest prediction. A directed
// opening covers the empty, full, duplicate and not-found cases, then
// phases of random commands with varying push bias and random issue gaps.
// ----------------------------------------------------------------------------

module tb_ordered_page_list
  import opl_pkg::*;
;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_OPS   = 950;
  localparam int MAX_REPORTED = 10;

  // Behavioural copy of the list, front of the list at index 0.
  class page_list_scoreboard;
    logic [PAGE_W-1:0] held[$];
    opl_out_t          expected_q[$];
    int                errors;

    function void note_input(opl_in_t item);
      opl_out_t res;
      bit       found;
      res   = '0;
      found = 1'b0;
      case (item.func)
        FN_PUSH_FRONT: begin
          if (held.size() >= LIST_DEPTH) res.status = ST_FULL;
          else held.insert(0, item.page);
        end
        FN_POP_BACK: begin
          if (held.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.removed_page = held[held.size()-1];
            held.delete(held.size()-1);
          end
        end
        FN_REMOVE: begin
          if (held.size() == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.status = ST_NOT_FOUND;
            // only the match nearest the front goes
            for (int i = 0; i < held.size() && !found; i++) begin
              if (held[i] == item.page) begin
                res.removed_page = held[i];
                res.status       = ST_OK;
                held.delete(i);
                found = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      res.front_page  = (held.size() != 0) ? held[0] : '0;
      res.back_page   = (held.size() != 0) ? held[held.size()-1] : '0;
      res.entry_count = CNT_W'(held.size());
      expected_q.push_back(res);
    endfunction

    function void check_result(opl_out_t got);
      opl_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTED)
          $display("%0t: result with nothing outstanding: rm=%h st=%0d fr=%h bk=%h n=%0d",
                   $realtime, got.removed_page, got.status, got.front_page,
                   got.back_page, got.entry_count);
        return;
      end
      want = expected_q.pop_front();
      if (got.removed_page != want.removed_page || got.status != want.status ||
          got.front_page != want.front_page || got.back_page != want.back_page ||
          got.entry_count != want.entry_count) begin
        errors++;
        if (errors <= MAX_REPORTED) begin
          $display("%0t: mismatch exp rm=%h st=%0d fr=%h bk=%h n=%0d", $realtime,
                   want.removed_page, want.status, want.front_page, want.back_page,
                   want.entry_count);
          $display("%0t:          got rm=%h st=%0d fr=%h bk=%h n=%0d", $realtime,
                   got.removed_page, got.status, got.front_page, got.back_page,
                   got.entry_count);
        end
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  opl_in_t  in_data;
  logic     out_valid;
  opl_out_t out_data;

  page_list_scoreboard sb;
  bit                  no_gap;

  ordered_page_list #(
    .DEPTH      (LIST_DEPTH),
    .PAGE_WIDTH (PAGE_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic issue_op(input func_t f, input logic [PAGE_W-1:0] pg);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_data.func <= f;
    in_data.page <= pg;
    do @(posedge clk); while (busy);
    sb.note_input('{func: f, page: pg});
    @(negedge clk);
  endtask

  // Mostly pages already held, so removes find matches; small pool for duplicates.
  function automatic logic [PAGE_W-1:0] pick_page(bit prefer_held);
    if (prefer_held && sb.held.size() != 0 && $urandom_range(0, 3) != 0)
      return sb.held[$urandom_range(0, sb.held.size() - 1)];
    if ($urandom_range(0, 1) == 0) return PAGE_W'($urandom_range(0, 7));
    return PAGE_W'($urandom);
  endfunction

  initial begin
    int    push_pct;
    int    roll;
    func_t f;

    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    no_gap  = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty list cases
    issue_op(FN_PEEK, 16'h0000);
    issue_op(FN_POP_BACK, 16'h0000);
    issue_op(FN_REMOVE, 16'hFFFF);
    // extremes and a duplicate, then remove the one nearest the front
    issue_op(FN_PUSH_FRONT, 16'hFFFF);
    issue_op(FN_PUSH_FRONT, 16'h0000);
    issue_op(FN_PUSH_FRONT, 16'hFFFF);
    issue_op(FN_REMOVE, 16'hFFFF);
    issue_op(FN_REMOVE, 16'h1234);
    issue_op(FN_POP_BACK, 16'h5A5A);
    // fill to capacity, refuse one more, then remove the pages held at the tail and the front
    while (sb.held.size() < LIST_DEPTH) issue_op(FN_PUSH_FRONT, pick_page(1'b0));
    issue_op(FN_PUSH_FRONT, 16'hA5A5);
    issue_op(FN_PEEK, 16'hFFFF);
    issue_op(FN_REMOVE, sb.held[LIST_DEPTH-1]);
    issue_op(FN_REMOVE, sb.held[0]);

    push_pct = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 75;
        endcase
        no_gap = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        f = FN_PUSH_FRONT;
      end else begin
        roll = $urandom_range(0, 9);
        f = (roll < 3) ? FN_POP_BACK : (roll < 8) ? FN_REMOVE : FN_PEEK;
      end
      issue_op(f, pick_page(f == FN_REMOVE));
    end
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: ordered_page_list.f
hdl/opl_pkg.sv
hdl/ordered_page_list.sv
tb/tb_ordered_page_list.sv
